>>> rtl/sq8_pkg.sv
// ----------------------------------------------------------------------------
// sq8_pkg
// Shared types and constants for the symmetric int8 quantiser.
// ----------------------------------------------------------------------------
package sq8_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int Q_W         = 8;
  localparam int SCALE_W     = 23;
  localparam int MAX_LEN_DEF = 64;
  localparam int MAX_W       = 16;

  // divider geometry
  localparam int DVD_W       = 24;
  localparam int DVS_W       = 17;
  localparam int QB_W        = 5;
  localparam int QUOT_W      = 23;

  localparam logic [QB_W-1:0]    SCALE_QBITS = QB_W'(23);
  localparam logic [QB_W-1:0]    Q_QBITS     = QB_W'(7);
  localparam logic [7:0]         QMAX2       = 8'd254;
  localparam logic [DVD_W-1:0]   SCALE_NUM   = DVD_W'(127 * 131072);
  localparam logic [SCALE_W-1:0] SCALE_ONE   = SCALE_W'(65536);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0]  quantized;
    logic [SCALE_W-1:0]     scale;
    logic                   last_res;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [QB_W-1:0]   qbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/sq8_div.sv
// ----------------------------------------------------------------------------
// sq8_div
// Restoring divider, one quotient bit per cycle, quotient length per request.
// ----------------------------------------------------------------------------
module sq8_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sq8_pkg::div_req_t req,
  output sq8_pkg::div_rsp_t rsp
);
  import sq8_pkg::*;

  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [QB_W-1:0]   cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    trial;
  logic              ge;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_r};
    if (ge) begin
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DVS_W-1:0];
    end
    quot_nxt = {quot_r[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.qbits;
        rem_r  <= DVS_W'(req.dividend >> req.qbits);
        dvd_r  <= req.dividend << (QB_W'(DVD_W) - req.qbits);
        dvs_r  <= req.divisor;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= quot_nxt;
        dvd_r  <= dvd_r << 1;
        cnt_r  <= cnt_r - QB_W'(1);
        if (cnt_r == QB_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

>>> rtl/sq8_jobq.sv
// ----------------------------------------------------------------------------
// sq8_jobq
// Two-entry queue of closed blocks between the load and emit sides.
// ----------------------------------------------------------------------------
module sq8_jobq #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);
  import sq8_pkg::*;

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_data  = ent_r[rd_ptr_r];

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("sq8_jobq: transfer into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("sq8_jobq: pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("sq8_jobq: occupancy out of range");

endmodule

>>> rtl/sq8_front.sv
// ----------------------------------------------------------------------------
// sq8_front
// Load side: stores samples into the open bank, tracks count and max |x|.
// ----------------------------------------------------------------------------
module sq8_front #(
  parameter int MAX_LEN = sq8_pkg::MAX_LEN_DEF,
  parameter int CNT_W   = $clog2(MAX_LEN + 1),
  parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic                         full,
  input  sq8_pkg::in_t                 data,
  output logic                         wr_en,
  output logic                         wr_bank,
  output logic [IDX_W-1:0]             wr_idx,
  output logic [sq8_pkg::SAMPLE_W-1:0] wr_data,
  output logic                         job_push,
  output logic                         job_bank,
  output logic [CNT_W-1:0]             job_n,
  output logic [sq8_pkg::MAX_W-1:0]    job_m
);
  import sq8_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [MAX_W-1:0]  max_r;
  logic              bank_r;
  logic              accept;
  logic              store;
  logic [MAX_W:0]    sx;
  logic [MAX_W:0]    ax;
  logic [MAX_W-1:0]  max_new;
  logic [CNT_W-1:0]  count_new;

  always_comb begin
    accept    = push && !full;
    store     = count_r < CNT_W'(MAX_LEN);
    sx        = {data.sample[SAMPLE_W-1], data.sample};
    ax        = sx[MAX_W] ? (~sx + (MAX_W+1)'(1)) : sx;
    max_new   = (store && (ax > {1'b0, max_r})) ? ax[MAX_W-1:0] : max_r;
    count_new = store ? (count_r + CNT_W'(1)) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      max_r   <= '0;
      bank_r  <= 1'b0;
    end else if (accept) begin
      if (data.last) begin
        count_r <= '0;
        max_r   <= '0;
        bank_r  <= ~bank_r;
      end else begin
        count_r <= count_new;
        max_r   <= max_new;
      end
    end
  end

  assign wr_en    = accept && store;
  assign wr_bank  = bank_r;
  assign wr_idx   = count_r[IDX_W-1:0];
  assign wr_data  = data.sample;
  assign job_push = accept && data.last;
  assign job_bank = bank_r;
  assign job_n    = count_new;
  assign job_m    = max_new;

endmodule

>>> rtl/sq8_back.sv
// ----------------------------------------------------------------------------
// sq8_back
// Emit side: holds the two sample banks, divides and drives the result register.
// ----------------------------------------------------------------------------
module sq8_back #(
  parameter int MAX_LEN = sq8_pkg::MAX_LEN_DEF,
  parameter int CNT_W   = $clog2(MAX_LEN + 1),
  parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic                         wr_bank,
  input  logic [IDX_W-1:0]             wr_idx,
  input  logic [sq8_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         job_valid,
  input  logic                         job_bank,
  input  logic [CNT_W-1:0]             job_n,
  input  logic [sq8_pkg::MAX_W-1:0]    job_m,
  output logic                         job_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output sq8_pkg::out_t                out_data
);
  import sq8_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE_WAIT, S_READ, S_CALC, S_QWAIT, S_EMIT
  } state_t;

  state_t                     state_r;
  logic [SAMPLE_W-1:0]        mem [2][MAX_LEN];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [CNT_W-1:0]           k_r;
  logic [SCALE_W-1:0]         scale_r;
  logic [6:0]                 q_r;
  logic                       neg_r;
  logic                       out_valid_r;
  out_t                       out_r;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic [MAX_W:0]             sx;
  logic [MAX_W:0]             av;
  logic                       m_zero;
  logic                       out_free;
  logic                       is_last;
  logic [Q_W-1:0]             q_ext;

  sq8_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_idx] <= wr_data;
    end
    if (state_r == S_READ) begin
      rd_data_r <= mem[job_bank][k_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    m_zero   = job_m == '0;
    sx       = {rd_data_r[SAMPLE_W-1], rd_data_r};
    av       = sx[MAX_W] ? (~sx + (MAX_W+1)'(1)) : sx;
    out_free = !out_valid_r || out_pop;
    is_last  = (k_r + CNT_W'(1)) == job_n;
    q_ext    = {1'b0, q_r};
    job_pop  = (state_r == S_EMIT) && out_free && is_last;

    div_req.divisor = {job_m, 1'b0};
    if (state_r == S_IDLE) begin
      div_req.start    = job_valid && !m_zero;
      div_req.dividend = SCALE_NUM + DVD_W'(job_m);
      div_req.qbits    = SCALE_QBITS;
    end else begin
      div_req.start    = (state_r == S_CALC) && !m_zero;
      div_req.dividend = DVD_W'(av) * DVD_W'(QMAX2) + DVD_W'(job_m);
      div_req.qbits    = Q_QBITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          k_r <= '0;
          if (job_valid) begin
            if (m_zero) begin
              scale_r <= SCALE_ONE;
              state_r <= S_READ;
            end else begin
              state_r <= S_SCALE_WAIT;
            end
          end
        end
        S_SCALE_WAIT: begin
          if (div_rsp.done) begin
            scale_r <= div_rsp.quot[SCALE_W-1:0];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          neg_r <= rd_data_r[SAMPLE_W-1];
          if (m_zero) begin
            q_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_QWAIT;
          end
        end
        S_QWAIT: begin
          if (div_rsp.done) begin
            q_r     <= div_rsp.quot[6:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_r.quantized <= neg_r ? -q_ext : q_ext;
            out_r.scale     <= scale_r;
            out_r.last_res  <= is_last;
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + CNT_W'(1);
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   !out_empty |-> out_data.quantized != -8'sd128)
    else $error("sq8_back: quantised value out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
                   !out_empty |-> out_data.scale != '0)
    else $error("sq8_back: zero scale");
  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r != S_IDLE |-> job_valid)
    else $error("sq8_back: block lost while emitting");
  assert property (@(posedge clk) disable iff (!rst_n)
                   div_rsp.done |-> (state_r == S_SCALE_WAIT || state_r == S_QWAIT))
    else $error("sq8_back: unexpected divider completion");

endmodule

>>> rtl/symmetric_int8_quantizer.sv
// Load: one sample per cycle while a sample bank is free (two banks, one per closed block).
// Emit: the 23-bit scale is divided once per block, then each result is read, divided
// and emitted in turn, one at a time, on the one-bit-per-cycle divider shared by scale
// and quantised values; an all-zero block skips the divider: scale SCALE_ONE, results 0.
// Reset (rst_n low, synchronous) empties the queue and result register; stored samples
// keep no reset value and are only read once written.
// ----------------------------------------------------------------------------
// symmetric_int8_quantizer
// Absmax int8 quantiser: collects a block, then emits one result per stored sample (up to MAX_LEN).
// ----------------------------------------------------------------------------
module symmetric_int8_quantizer #(
  parameter int MAX_LEN = sq8_pkg::MAX_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  sq8_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output sq8_pkg::out_t out_data
);
  import sq8_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int JOB_W = 1 + CNT_W + MAX_W;

  logic                wr_en;
  logic                wr_bank;
  logic [IDX_W-1:0]    wr_idx;
  logic [SAMPLE_W-1:0] wr_data;
  logic                job_push;
  logic                push_bank;
  logic [CNT_W-1:0]    push_n;
  logic [MAX_W-1:0]    push_m;
  logic                job_pop;
  logic                job_valid;
  logic [JOB_W-1:0]    head;

  sq8_front #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .data     (in_data),
    .wr_en    (wr_en),
    .wr_bank  (wr_bank),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data),
    .job_push (job_push),
    .job_bank (push_bank),
    .job_n    (push_n),
    .job_m    (push_m)
  );

  sq8_jobq #(
    .W (JOB_W)
  ) u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_data  ({push_bank, push_n, push_m}),
    .full       (in_full),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_data  (head)
  );

  sq8_back #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .IDX_W   (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_idx    (wr_idx),
    .wr_data   (wr_data),
    .job_valid (job_valid),
    .job_bank  (head[JOB_W-1]),
    .job_n     (head[JOB_W-2:MAX_W]),
    .job_m     (head[MAX_W-1:0]),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
